// File: sv/bsort_pkg.sv
package bsort_pkg;

   localparam int DATA_W = 32;
   localparam int SORT_SIZE_DEF = 16;

   typedef logic signed [DATA_W-1:0] data_type;

endpackage

// File: sv/bitonic_sorter_core.sv
// Channel  | Direction | Handshake                        | Payload
// req      | in        | req_valid / req_ready            | req_value
// rsp      | out       | rsp_valid / rsp_ready            | rsp_sorted_value, rsp_last
// csr      | in        | csr_we (no wait)                 | csr_wdata (ascending)
//
// Loading takes one cycle per beat while req_ready is high.
// The network runs on a two-read, one-write buffer memory: each compare-exchange
// reads both words, then writes the lower, then the upper; with D = floor(log2 N)
// the sort performs (N/2) * D * (D + 1) / 2 compare-exchanges, 80 for N = 16.
// Each result beat is read from the buffer, then offered and held until rsp_ready takes it.
// Synchronous reset clears the control state; the buffer holds no reset value.
// No input beat is taken while a block is sorted or drained; rsp stalls hold the result.
module bitonic_sorter_core #(
   parameter int SORT_SIZE = bsort_pkg::SORT_SIZE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [bsort_pkg::DATA_W-1:0] req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [bsort_pkg::DATA_W-1:0] rsp_sorted_value,
   output logic                           rsp_last,
   input  logic                           csr_we,
   input  logic                           csr_wdata
);

   localparam int AW = $clog2(SORT_SIZE);
   localparam int DEPTH = $clog2(SORT_SIZE + 1) - 1;
   localparam int LW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW = (DEPTH > 1) ? DEPTH - 1 : 1;

   localparam logic [2:0] S_LOAD = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_CMP  = 3'd2;
   localparam logic [2:0] S_WR2  = 3'd3;
   localparam logic [2:0] S_ORD  = 3'd4;
   localparam logic [2:0] S_OLD  = 3'd5;
   localparam logic [2:0] S_OWT  = 3'd6;

   logic [2:0]                 state_ff, state_in;
   logic [AW-1:0]              load_cnt_ff, load_cnt_in;
   logic [LW-1:0]              s_ff, s_in;
   logic [LW-1:0]              t_ff, t_in;
   logic [PW-1:0]              p_ff, p_in;
   logic [AW-1:0]              o_ff, o_in;
   logic [AW-1:0]              out_idx_ff, out_idx_in;
   bsort_pkg::data_type        hold_ff, hold_in;
   logic                       asc_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_last_ff, rsp_last_in;
   bsort_pkg::data_type        rsp_value_ff, rsp_value_in;

   logic [AW:0]                base;
   logic [AW:0]                half;
   logic [AW-1:0]              addr_a;
   logic [AW-1:0]              addr_b;
   logic                       dir_up;
   logic                       swap;
   logic                       o_last;
   logic                       p_last;
   logic                       t_last;
   logic [PW-1:0]              sh;

   logic                       ram_we;
   logic [AW-1:0]              ram_waddr;
   bsort_pkg::data_type        ram_wdata;
   logic [AW-1:0]              ram_raddr_a;
   bsort_pkg::data_type        ram_rdata_a;
   bsort_pkg::data_type        ram_rdata_b;

   always_comb begin
      base = '0;
      dir_up = asc_ff;
      for (int i = 1; i <= DEPTH; i++) begin
         sh = p_ff >> (int'(t_ff) - i);
         if (i <= int'(t_ff) && sh[0]) begin
            base = base + (AW + 1)'(SORT_SIZE >> i);
         end
      end
      if (s_ff != '0) begin
         sh = p_ff >> (int'(t_ff) - int'(s_ff));
         dir_up = !sh[0];
      end
      half = (AW + 1)'(SORT_SIZE >> (int'(t_ff) + 1));
      addr_a = AW'(base + (AW + 1)'(o_ff));
      addr_b = AW'(base + (AW + 1)'(o_ff) + half);
      o_last = ((AW + 1)'(o_ff) == half - 1'b1);
      p_last = (int'(p_ff) == (1 << int'(t_ff)) - 1);
      t_last = (int'(t_ff) == DEPTH - 1);
      swap = dir_up ? (ram_rdata_a > ram_rdata_b) : !(ram_rdata_a > ram_rdata_b);
   end

   always_comb begin
      state_in = state_ff;
      load_cnt_in = load_cnt_ff;
      s_in = s_ff;
      t_in = t_ff;
      p_in = p_ff;
      o_in = o_ff;
      out_idx_in = out_idx_ff;
      hold_in = hold_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in = rsp_last_ff;
      rsp_value_in = rsp_value_ff;
      ram_we = 1'b0;
      ram_waddr = addr_a;
      ram_wdata = hold_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               ram_we = 1'b1;
               ram_waddr = load_cnt_ff;
               ram_wdata = req_value;
               if (int'(load_cnt_ff) == SORT_SIZE - 1) begin
                  load_cnt_in = '0;
                  s_in = LW'(DEPTH - 1);
                  t_in = LW'(DEPTH - 1);
                  p_in = '0;
                  o_in = '0;
                  state_in = S_RD;
               end else begin
                  load_cnt_in = load_cnt_ff + 1'b1;
               end
            end
         end
         S_RD: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            ram_we = 1'b1;
            ram_waddr = addr_a;
            ram_wdata = swap ? ram_rdata_b : ram_rdata_a;
            hold_in = swap ? ram_rdata_a : ram_rdata_b;
            state_in = S_WR2;
         end
         S_WR2: begin
            ram_we = 1'b1;
            ram_waddr = addr_b;
            ram_wdata = hold_ff;
            state_in = S_RD;
            if (!o_last) begin
               o_in = o_ff + 1'b1;
            end else begin
               o_in = '0;
               if (!p_last) begin
                  p_in = p_ff + 1'b1;
               end else begin
                  p_in = '0;
                  if (!t_last) begin
                     t_in = t_ff + 1'b1;
                  end else if (s_ff == '0) begin
                     out_idx_in = '0;
                     state_in = S_ORD;
                  end else begin
                     s_in = s_ff - 1'b1;
                     t_in = s_ff - 1'b1;
                  end
               end
            end
         end
         S_ORD: begin
            state_in = S_OLD;
         end
         S_OLD: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = ram_rdata_a;
            rsp_last_in = (int'(out_idx_ff) == SORT_SIZE - 1);
            state_in = S_OWT;
         end
         S_OWT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = S_LOAD;
               end else begin
                  out_idx_in = out_idx_ff + 1'b1;
                  state_in = S_OLD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
      ram_raddr_a = (state_ff == S_RD || state_ff == S_CMP || state_ff == S_WR2)
                    ? addr_a : out_idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         load_cnt_ff <= '0;
         s_ff <= '0;
         t_ff <= '0;
         p_ff <= '0;
         o_ff <= '0;
         out_idx_ff <= '0;
         asc_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         load_cnt_ff <= load_cnt_in;
         s_ff <= s_in;
         t_ff <= t_in;
         p_ff <= p_in;
         o_ff <= o_in;
         out_idx_ff <= out_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            asc_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      rsp_last_ff <= rsp_last_in;
      rsp_value_ff <= rsp_value_in;
   end

   bsort_ram #(
      .WIDTH(bsort_pkg::DATA_W),
      .DEPTH(SORT_SIZE)
   ) u_ram (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   (ram_wdata),
      .raddr_a (ram_raddr_a),
      .raddr_b (addr_b),
      .rdata_a (ram_rdata_a),
      .rdata_b (ram_rdata_b)
   );

   assign req_ready = (state_ff == S_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_last = rsp_last_ff;

endmodule

// File: sv/bsort_ram.sv
module bsort_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule

// File: sv/bsort_checker.sv
module bsort_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic signed [bsort_pkg::DATA_W-1:0] req_value,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [bsort_pkg::DATA_W-1:0] rsp_sorted_value,
   input logic                               rsp_last,
   input logic                               csr_we,
   input logic                               csr_wdata
);

   // A result is never offered on the cycle after reset.
   a_rst_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // Loading and draining never overlap.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a result is pending");

   // The final beat of a block ends the drain.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid)
      else $error("result offered after the last beat");

   // Mid-block, the loader stays closed.
   a_mid_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> !req_ready)
      else $error("input opened before the block was drained");

   // A stalled result holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sorted_value)
                                  && $stable(rsp_last))
      else $error("stalled result changed");

endmodule

bind bitonic_sorter_core bsort_checker u_bsort_checker (.*);

// File: tb/sorted_block_checker.sv
`timescale 1ns / 100ps

module sorted_block_checker #(
   parameter int BLOCK_LEN = bsort_pkg::SORT_SIZE_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  bsort_pkg::data_type req_value,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  bsort_pkg::data_type rsp_sorted_value,
   input  logic                rsp_last,
   input  logic                csr_we,
   input  logic                csr_wdata,
   output int                  fail_count,
   output int                  pending
);

   typedef struct packed {
      bsort_pkg::data_type value;
      logic                last;
   } sorted_beat_type;

   sorted_beat_type     sorted_q[$];
   sorted_beat_type     head;
   bsort_pkg::data_type load_buf [BLOCK_LEN];
   int                  load_cnt;
   logic                dir_up;

   // Every stage below the last sorts its sub-blocks in alternating directions;
   // the final merge follows the configured direction.
   function automatic void run_network();
      int                  k;
      int                  j;
      int                  i;
      int                  p;
      logic                up;
      bsort_pkg::data_type a;
      bsort_pkg::data_type b;
      for (k = 2; k <= BLOCK_LEN; k = k * 2) begin
         for (j = k / 2; j > 0; j = j / 2) begin
            for (i = 0; i < BLOCK_LEN; i++) begin
               p = i ^ j;
               if (p > i) begin
                  up = (k == BLOCK_LEN) ? dir_up : ((i & k) == 0);
                  a = load_buf[i];
                  b = load_buf[p];
                  if (up ? (a > b) : (a < b)) begin
                     load_buf[i] = b;
                     load_buf[p] = a;
                  end
               end
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         load_cnt = 0;
         dir_up = 1'b1;
         sorted_q.delete();
         fail_count = 0;
      end else begin
         if (csr_we)
            dir_up = csr_wdata;
         if (req_valid && req_ready) begin
            load_buf[load_cnt] = req_value;
            load_cnt++;
            if (load_cnt == BLOCK_LEN) begin
               run_network();
               for (int i = 0; i < BLOCK_LEN; i++) begin
                  head.value = load_buf[i];
                  head.last = (i == BLOCK_LEN - 1);
                  sorted_q.push_back(head);
               end
               load_cnt = 0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (sorted_q.size() == 0) begin
               $error("rsp beat with nothing pending: sorted_value %0d, last %0b",
                      rsp_sorted_value, rsp_last);
               fail_count++;
            end else begin
               head = sorted_q.pop_front();
               if (rsp_sorted_value !== head.value) begin
                  $error("sorted_value: expected %0d, got %0d",
                         $signed(head.value), rsp_sorted_value);
                  fail_count++;
               end
               if (rsp_last !== head.last) begin
                  $error("last: expected %0b, got %0b", head.last, rsp_last);
                  fail_count++;
               end
            end
         end
      end
      pending = sorted_q.size();
   end

endmodule

// File: tb/tb_bitonic_sorter_core.sv
`timescale 1ns / 100ps

module tb_bitonic_sorter_core;

   localparam int BLOCK_LEN   = bsort_pkg::SORT_SIZE_DEF;
   localparam int RAND_BLOCKS = 6;
   localparam int HOLD_BEAT   = 4;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE      = 20;
   localparam int TAIL        = 50;
   localparam int LIMIT       = 200000;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   bsort_pkg::data_type req_value;
   logic                rsp_valid;
   logic                rsp_ready;
   bsort_pkg::data_type rsp_sorted_value;
   logic                rsp_last;
   logic                csr_we;
   logic                csr_wdata;
   int                  fail_count;
   int                  pending;
   int                  cycle_count = 0;
   logic                steady;
   logic                rcv_steady;

   bsort_pkg::data_type directed [16] = '{
      32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, -32'sd1,
      32'sd1,         32'sd5,         32'sd5,         32'sd5,
      -32'sd5,        32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh4000_0000,
      -32'sh4000_0000, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_0000
   };

   always #2 clock = ~clock;

   bitonic_sorter_core #(
      .SORT_SIZE(BLOCK_LEN)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sorted_value(rsp_sorted_value),
      .rsp_last        (rsp_last),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   sorted_block_checker #(
      .BLOCK_LEN(BLOCK_LEN)
   ) checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sorted_value(rsp_sorted_value),
      .rsp_last        (rsp_last),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   function automatic bsort_pkg::data_type pick_value();
      case ($urandom_range(0, 5))
         0: return bsort_pkg::data_type'($urandom_range(0, 8)) - 32'sd4;
         1: return 32'sh8000_0000;
         2: return 32'sh7FFF_FFFF;
         default: return bsort_pkg::data_type'($urandom);
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat with valid
   // still high, so the next call or a settle decides its level in the same step.
   task automatic send_value(input bsort_pkg::data_type v);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic set_direction(input logic up);
      csr_we <= 1'b1;
      csr_wdata <= up;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int stall;
      int beats;
      rsp_ready = 1'b0;
      rcv_steady = 1'b0;
      beats = 0;
      @(negedge clock);
      forever begin
         if (beats % BLOCK_LEN == 0)
            rcv_steady = ($urandom_range(0, 3) == 0);
         stall = rcv_steady ? 0 : $urandom_range(0, 12);
         // A long hold-off in the first block's drain keeps the loader closed while the next block is offered.
         if (beats == HOLD_BEAT)
            stall = HOLD_CYCLES;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         beats++;
         @(negedge clock);
      end
   end

   initial begin
      int blk;
      int i;
      int split;
      reset = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      csr_we = 1'b0;
      csr_wdata = 1'b1;
      steady = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The first half loads under the reset direction; the block completes descending.
      for (i = 0; i < BLOCK_LEN; i++) begin
         if (i == BLOCK_LEN / 2) begin
            settle();
            set_direction(1'b0);
         end
         send_value(directed[i]);
      end

      for (blk = 0; blk < RAND_BLOCKS; blk++) begin
         steady = ($urandom_range(0, 3) == 0);
         split = 0;
         if (blk == 2) begin
            settle();
            set_direction(1'b1);
         end else if (blk > 2) begin
            if ($urandom_range(0, 1) == 1) begin
               settle();
               set_direction(1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 2) == 0)
               split = $urandom_range(1, BLOCK_LEN - 1);
         end
         for (i = 0; i < BLOCK_LEN; i++) begin
            if (split != 0 && i == split) begin
               settle();
               set_direction(1'($urandom_range(0, 1)));
            end
            send_value(pick_value());
         end
      end

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (TAIL) @(negedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
